/* hdl/jspl_pkg.sv */
package jspl_pkg;

    // Width of the internal byte counters
    localparam int unsigned OFFSET_WIDTH = 32;
    localparam int unsigned RESULT_WIDTH = 32;

    // Marker bytes
    localparam logic [7:0] BYTE_PREFIX   = 8'hFF;
    localparam logic [7:0] CODE_SOI      = 8'hD8;
    localparam logic [7:0] CODE_EOI      = 8'hD9;
    localparam logic [7:0] CODE_SOS      = 8'hDA;
    localparam logic [7:0] CODE_RST_LO   = 8'hD0;
    localparam logic [7:0] CODE_DEF_HI   = 8'hDD;
    localparam logic [7:0] CODE_APP0     = 8'hE0;
    localparam logic [7:0] CODE_APP1     = 8'hE1;
    localparam logic [7:0] CODE_APP15    = 8'hEF;

    typedef logic [OFFSET_WIDTH-1:0] offset_t;

    // One input request: a file byte and its end flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    // One result request: summary of a whole stream
    typedef struct packed {
        logic                    is_jpeg;
        logic                    truncated;
        logic                    payload_found;
        logic [RESULT_WIDTH-1:0] payload_start;
        logic [RESULT_WIDTH-1:0] total_length;
    } out_item_t;

    // Codes that form a marker after the prefix
    function automatic logic is_marker_code(input logic [7:0] c);
        is_marker_code = ((c >= CODE_RST_LO) && (c <= CODE_DEF_HI)) ||
                         ((c >= CODE_APP0) && (c <= CODE_APP15));
    endfunction

endpackage

/* hdl/jspl_parser.sv */
module jspl_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  jspl_pkg::in_item_t item,
    output jspl_pkg::out_item_t res
);
    import jspl_pkg::*;

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    offset_t     pos_reg, pos_next;
    offset_t     scan_offset_reg, scan_offset_next;
    logic        prefix_reg, prefix_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] skip_reg, skip_next;
    logic        soi_ok_reg, soi_ok_next;
    logic [7:0]  prev_reg, prev_next;

    offset_t     total;
    offset_t     start;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;
    logic        ends_ok;
    logic        jpeg;
    logic [7:0]  b;
    logic        soi_ok_step;
    offset_t     scan_offset_step;

    assign b = item.data_byte;

    // Saturating count including this byte
    assign total = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign start = (pos_reg != '0) ? pos_reg - 1'b1 : '0;
    assign seg_len = {len_hi_reg, b};
    assign skip_dec = (skip_reg != '0) ? skip_reg - 16'd1 : skip_reg;

    // Per-byte state update
    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        scan_offset_next = scan_offset_reg;
        prefix_next      = prefix_reg;
        len_hi_next      = len_hi_reg;
        skip_next        = skip_reg;
        soi_ok_next      = soi_ok_reg;
        prev_next        = prev_reg;

        // start-of-image check on the first two bytes
        if (pos_reg == '0)
        begin
            soi_ok_next = (b == BYTE_PREFIX);
        end
        else if (pos_reg == offset_t'(1))
        begin
            soi_ok_next = soi_ok_reg && (b == CODE_SOI);
        end

        unique case (phase_reg)
            PH_SCAN:
            begin
                if (prefix_reg)
                begin
                    // a run of prefix bytes keeps it armed
                    if (b != BYTE_PREFIX)
                    begin
                        prefix_next = 1'b0;
                        if (is_marker_code(b))
                        begin
                            if ((b >= CODE_APP1) && (b <= CODE_APP15))
                            begin
                                phase_next = PH_LEN_HI;
                            end
                            else if ((b == CODE_SOS) && (scan_offset_reg == '0) &&
                                     (start != '0))
                            begin
                                scan_offset_next = start;
                            end
                        end
                    end
                end
                else if (b == BYTE_PREFIX)
                begin
                    prefix_next = 1'b1;
                end
            end
            PH_LEN_HI:
            begin
                len_hi_next = b;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                // short lengths count as two
                skip_next  = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
                phase_next = ((seg_len < 16'd2) || (seg_len == 16'd2)) ? PH_SCAN : PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == '0)
                begin
                    phase_next = PH_SCAN;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
            end
        endcase

        prev_next = b;
        pos_next  = total;

        // values after this byte, before the end-of-stream clear
        soi_ok_step      = soi_ok_next;
        scan_offset_step = scan_offset_next;

        // end of stream: back to reset for the next file
        if (item.last)
        begin
            phase_next       = PH_SCAN;
            pos_next         = '0;
            scan_offset_next = '0;
            prefix_next      = 1'b0;
            len_hi_next      = '0;
            skip_next        = '0;
            soi_ok_next      = 1'b0;
            prev_next        = '0;
        end
    end

    // Result of the stream, valid with the last byte
    assign jpeg    = (total > offset_t'(3)) && soi_ok_step;
    assign ends_ok = (prev_reg == BYTE_PREFIX) && (b == CODE_EOI);

    // an SOS whose code is the last byte still counts
    always_comb
    begin
        res.is_jpeg       = jpeg;
        res.truncated     = jpeg && !ends_ok;
        res.payload_found = (scan_offset_step != '0);
        res.payload_start = RESULT_WIDTH'(scan_offset_step);
        res.total_length  = RESULT_WIDTH'(total);
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SCAN;
            pos_reg         <= '0;
            scan_offset_reg <= '0;
            prefix_reg      <= 1'b0;
            len_hi_reg      <= '0;
            skip_reg        <= '0;
            soi_ok_reg      <= 1'b0;
            prev_reg        <= '0;
        end
        else if (go)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            scan_offset_reg <= scan_offset_next;
            prefix_reg      <= prefix_next;
            len_hi_reg      <= len_hi_next;
            skip_reg        <= skip_next;
            soi_ok_reg      <= soi_ok_next;
            prev_reg        <= prev_next;
        end
    end

    // Skipping always has bytes left
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIP) |-> (skip_reg != '0))
        else $error("skip phase with nothing left to skip");

    // A recorded SOS lies behind the current position
    a_offset_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_offset_reg != '0) |-> (scan_offset_reg < pos_reg))
        else $error("recorded SOS offset not behind position");

    // Last byte returns the parser to its start
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (go && item.last) |=> ((pos_reg == '0) && (phase_reg == PH_SCAN) && !prefix_reg))
        else $error("parser not cleared after last byte");

endmodule

/* hdl/jspl_out_stage.sv */
module jspl_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jspl_pkg::out_item_t res,
    output logic                free,
    output logic                result_valid,
    input  logic                result_stall,
    output jspl_pkg::out_item_t result
);
    import jspl_pkg::*;

    logic      vld_reg, vld_next;
    out_item_t data_reg;

    // Room for a new result when empty or draining this cycle
    assign free = !vld_reg || !result_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (!result_stall)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result_valid = vld_reg;
    assign result       = data_reg;

    // Never load over a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("result overwritten while stalled");

endmodule

/* hdl/jpeg_scan_payload_locator_top.sv */
// Scans a file streamed one byte per request (with a last flag) for JPEG
// markers, skips APP1..APP15 segments by their length field and, on the last
// byte, returns one result: JPEG signature, truncation, offset of the first
// start-of-scan marker and the byte count. One byte is taken every cycle
// unless bytes stall; a last byte passes the input register, and its result
// is then held in the result register until it is taken.
// Bytes stall only while a finished result is held in the result register
// and another last byte waits.
module jpeg_scan_payload_locator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  jspl_pkg::in_item_t  byte_req,
    output logic                result_valid,
    input  logic                result_stall,
    output jspl_pkg::out_item_t result
);
    import jspl_pkg::*;

    logic      in_vld_reg, in_vld_next;
    in_item_t  in_item_reg;
    logic      go;
    logic      out_free;
    logic      accept;
    out_item_t res;

    // Input register advances unless a result has nowhere to go
    assign go         = in_vld_reg && (!in_item_reg.last || out_free);
    assign byte_stall = in_vld_reg && !go;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (go)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= byte_req;
        end
    end

    jspl_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .item  (in_item_reg),
        .res   (res)
    );

    jspl_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (go && in_item_reg.last),
        .res          (res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* dv/jspl_summary_check.sv */
module jspl_summary_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_stall,
    input  jspl_pkg::in_item_t  byte_req,
    input  logic                result_valid,
    input  logic                result_stall,
    input  jspl_pkg::out_item_t result,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import jspl_pkg::*;

    typedef enum logic [1:0] {PH_SCAN, PH_LEN_HI, PH_LEN_LO, PH_SKIP} parse_phase_t;

    // Shadow copy of the parser state
    offset_t      pos_count;
    logic         prefix_armed;
    parse_phase_t phase;
    logic [7:0]   seg_len_hi;
    logic [15:0]  skip_left;
    offset_t      sos_offset;
    logic         soi_match;
    logic [7:0]   prior_byte;

    // Stream summaries predicted but not yet seen on the result side
    out_item_t expected_summaries[$];

    task automatic clear_parser();
        pos_count    = '0;
        prefix_armed = 1'b0;
        phase        = PH_SCAN;
        seg_len_hi   = '0;
        skip_left    = '0;
        sos_offset   = '0;
        soi_match    = 1'b0;
        prior_byte   = '0;
    endtask

    // Advance the parser by one accepted byte; on the last byte queue its summary
    task automatic advance_parser(input in_item_t req);
        logic [7:0]  b;
        offset_t     total;
        offset_t     start;
        logic [15:0] seg_len;
        logic        ends_ok;
        out_item_t   summary;
        b = req.data_byte;
        total = (pos_count == '1) ? pos_count : pos_count + 1'b1;

        // signature check on the first two bytes
        if (pos_count == 0)
            soi_match = (b == BYTE_PREFIX);
        else if (pos_count == 1)
            soi_match = soi_match && (b == CODE_SOI);

        case (phase)
            PH_SCAN:
            begin
                if (prefix_armed)
                begin
                    // another FF keeps the prefix armed
                    if (b != BYTE_PREFIX)
                    begin
                        prefix_armed = 1'b0;
                        if (((b >= CODE_RST_LO) && (b <= CODE_DEF_HI)) ||
                            ((b >= CODE_APP0) && (b <= CODE_APP15)))
                        begin
                            start = (pos_count != 0) ? pos_count - 1'b1 : '0;
                            if ((b >= CODE_APP1) && (b <= CODE_APP15))
                                phase = PH_LEN_HI;
                            else if ((b == CODE_SOS) && (sos_offset == 0) && (start != 0))
                                sos_offset = start;
                        end
                    end
                end
                else if (b == BYTE_PREFIX)
                begin
                    prefix_armed = 1'b1;
                end
            end
            PH_LEN_HI:
            begin
                seg_len_hi = b;
                phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                // short lengths count as 2: nothing left to skip
                seg_len = {seg_len_hi, b};
                if (seg_len < 2)
                    seg_len = 16'd2;
                skip_left = seg_len - 16'd2;
                phase = (skip_left == 0) ? PH_SCAN : PH_SKIP;
            end
            default:
            begin
                if (skip_left > 0)
                    skip_left = skip_left - 1'b1;
                if (skip_left == 0)
                    phase = PH_SCAN;
            end
        endcase

        if (!req.last)
        begin
            prior_byte = b;
            pos_count = total;
        end
        else
        begin
            ends_ok = (prior_byte == BYTE_PREFIX) && (b == CODE_EOI);
            summary.is_jpeg       = (total > 3) && soi_match;
            summary.truncated     = summary.is_jpeg && !ends_ok;
            summary.payload_found = (sos_offset != 0);
            summary.payload_start = RESULT_WIDTH'(sos_offset);
            summary.total_length  = RESULT_WIDTH'(total);
            expected_summaries.insert(expected_summaries.size(), summary);
            clear_parser();
        end
    endtask

    // Compare one result request with the oldest prediction
    task automatic check_summary(input out_item_t got);
        out_item_t want;
        if (expected_summaries.size() == 0)
        begin
            errors++;
            $display("%0t: result with none expected, actual %h", $time, got);
        end
        else
        begin
            want = expected_summaries.pop_front();
            if (got.is_jpeg !== want.is_jpeg)
            begin
                errors++;
                $display("%0t: is_jpeg expected %0d actual %0d",
                         $time, want.is_jpeg, got.is_jpeg);
            end
            if (got.truncated !== want.truncated)
            begin
                errors++;
                $display("%0t: truncated expected %0d actual %0d",
                         $time, want.truncated, got.truncated);
            end
            if (got.payload_found !== want.payload_found)
            begin
                errors++;
                $display("%0t: payload_found expected %0d actual %0d",
                         $time, want.payload_found, got.payload_found);
            end
            if (got.payload_start !== want.payload_start)
            begin
                errors++;
                $display("%0t: payload_start expected %0d actual %0d",
                         $time, want.payload_start, got.payload_start);
            end
            if (got.total_length !== want.total_length)
            begin
                errors++;
                $display("%0t: total_length expected %0d actual %0d",
                         $time, want.total_length, got.total_length);
            end
        end
    endtask

    // Monitor both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            expected_summaries.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_summary(result);
            if (byte_valid && !byte_stall)
                advance_parser(byte_req);
            pending = expected_summaries.size();
        end
    end

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jspl_pkg::*;

    localparam int BYTE_TARGET = 1350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    // codes used to build streams; of these the parser treats only DQT as a marker
    localparam logic [7:0] CODE_DHT   = 8'hC4;
    localparam logic [7:0] CODE_DQT   = 8'hDB;
    localparam logic [7:0] BYTE_STUFF = 8'h00;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_req;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    int errors;
    int pending;
    int cycle_count;
    int bytes_sent;
    int burst_left;
    logic gapless;

    // bytes of the stream being built
    logic [7:0] file_q[$];

    jpeg_scan_payload_locator_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_req     (byte_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    jspl_summary_check u_summary_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_req     (byte_req),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side backpressure: modes of random length
    initial
    begin
        int   mode;
        int   mode_left;
        int   run_left;
        logic run_level;
        mode_left = 0;
        run_left  = 0;
        run_level = 1'b0;
        mode      = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            case (mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 9) < 3);
                2: result_stall <= ($urandom_range(0, 9) < 8);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_level = ~run_level;
                        run_left = $urandom_range(1, 25);
                    end
                    run_left--;
                    result_stall <= run_level;
                end
            endcase
        end
    end

    // Append one byte to the stream being built
    task automatic add_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endtask

    // Send one byte request, idling between bursts unless gapless
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (burst_left == 0)
        begin
            if (!gapless)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        byte_req   <= '{data_byte: b, last: is_last};
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        int n;
        n = file_q.size();
        for (int i = 0; i < n; i++)
            send_byte(file_q[i], i == n - 1);
        file_q.delete();
    endtask

    // Byte biased toward prefixes and marker codes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: rand_byte = BYTE_PREFIX;
            1: rand_byte = 8'($urandom_range(CODE_RST_LO, CODE_APP15));
            default: rand_byte = 8'($urandom_range(0, 255));
        endcase
    endfunction

    // APPn segment: prefix, code, big-endian length and the bytes it covers
    task automatic push_app(input logic [7:0] code, input logic [15:0] seg_len);
        add_byte(BYTE_PREFIX);
        add_byte(code);
        add_byte(seg_len[15:8]);
        add_byte(seg_len[7:0]);
        for (int i = 2; i < seg_len; i++)
            add_byte(8'($urandom_range(0, 255)));
    endtask

    // Plausible file: SOI, header segments, SOS, entropy data, usually EOI
    task automatic build_jpeg();
        int cut;
        add_byte(BYTE_PREFIX);
        add_byte(CODE_SOI);
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 3) == 0)
                add_byte(BYTE_PREFIX);
            case ($urandom_range(0, 5))
                0:
                    push_app(8'($urandom_range(CODE_APP1, CODE_APP15)),
                             16'($urandom_range(0, 1)));
                1, 2, 3:
                    push_app(8'($urandom_range(CODE_APP1, CODE_APP15)),
                             16'($urandom_range(2, 12)));
                default:
                begin
                    add_byte(BYTE_PREFIX);
                    case ($urandom_range(0, 2))
                        0: add_byte(CODE_APP0);
                        1: add_byte(CODE_DQT);
                        default: add_byte(CODE_DHT);
                    endcase
                    repeat ($urandom_range(0, 4))
                        add_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            add_byte(BYTE_PREFIX);
        add_byte(BYTE_PREFIX);
        add_byte(CODE_SOS);
        repeat ($urandom_range(0, 20))
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    add_byte(BYTE_PREFIX);
                    add_byte(BYTE_STUFF);
                end
                1:
                begin
                    add_byte(BYTE_PREFIX);
                    add_byte(8'($urandom_range(CODE_RST_LO, CODE_DEF_HI)));
                end
                default: add_byte(rand_byte());
            endcase
        end
        if ($urandom_range(0, 3) != 0)
        begin
            add_byte(BYTE_PREFIX);
            add_byte(CODE_EOI);
        end
        // sometimes cut the file anywhere, even inside a segment header
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, file_q.size());
            file_q = file_q[0:cut-1];
        end
    endtask

    // Stimulus
    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_req   = '0;
        bytes_sent = 0;
        burst_left = 0;
        gapless    = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single zero byte, then a three byte stream
        file_q = '{BYTE_STUFF};
        send_file();
        file_q = '{BYTE_PREFIX, CODE_SOI, CODE_EOI};
        send_file();
        // smallest complete file
        file_q = '{BYTE_PREFIX, CODE_SOI, BYTE_PREFIX, CODE_EOI};
        send_file();
        // SOS at offset zero is ignored; a later one behind an FF run counts
        file_q = '{BYTE_PREFIX, CODE_SOS, BYTE_STUFF, BYTE_PREFIX, BYTE_PREFIX, CODE_SOS,
                   BYTE_PREFIX, CODE_EOI};
        send_file();
        // APP length below two, stream ends on a lone prefix
        file_q = '{BYTE_PREFIX, CODE_SOI, BYTE_PREFIX, CODE_APP1, 8'h00, 8'h01,
                   BYTE_PREFIX, CODE_SOS, BYTE_PREFIX};
        send_file();

        // Random files
        while (bytes_sent < BYTE_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
                gapless = ~gapless;
            case ($urandom_range(0, 9))
                6:
                begin
                    // noise
                    repeat ($urandom_range(1, 24))
                        add_byte(rand_byte());
                end
                7:
                begin
                    // short streams around the signature
                    repeat ($urandom_range(1, 4))
                    begin
                        case ($urandom_range(0, 4))
                            0, 1: add_byte(BYTE_PREFIX);
                            2: add_byte(CODE_SOI);
                            3: add_byte(CODE_EOI);
                            default: add_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
                8:
                begin
                    // SOS at the very start, maybe another later
                    add_byte(BYTE_PREFIX);
                    add_byte(CODE_SOS);
                    repeat ($urandom_range(0, 8))
                        add_byte(rand_byte());
                    if ($urandom_range(0, 1) == 1)
                    begin
                        add_byte(BYTE_PREFIX);
                        add_byte(CODE_SOS);
                    end
                    add_byte(BYTE_PREFIX);
                    add_byte(CODE_EOI);
                end
                9:
                begin
                    // long APP segment cut off by the end of the stream
                    add_byte(BYTE_PREFIX);
                    add_byte(CODE_SOI);
                    add_byte(BYTE_PREFIX);
                    add_byte(8'($urandom_range(CODE_APP1, CODE_APP15)));
                    add_byte(8'($urandom_range(0, 255)));
                    add_byte(8'($urandom_range(0, 255)));
                    repeat ($urandom_range(0, 10))
                        add_byte(rand_byte());
                end
                default: build_jpeg();
            endcase
            send_file();
        end

        // Drain
        byte_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
